FILE: hdl/lxsc_pkg.sv
// ----------------------------------------------------------------------------
// lxsc_pkg: shared types and constants of the lagged XOR keystream cipher
// Holds the key store geometry, generator constants and the port structs.
// ----------------------------------------------------------------------------
package lxsc_pkg;

    localparam int unsigned STREAM_LEN = 521;
    localparam int unsigned ADDR_W     = 10;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned SEED_WORDS = 17;
    localparam int unsigned LAG_NEAR   = 32;
    localparam int unsigned LAG_FAR    = STREAM_LEN - LAG_NEAR;
    localparam int unsigned REGEN_PASSES = 4;

    localparam logic [WORD_W-1:0] LCG_MUL   = 32'h5D58_8B65;
    localparam logic [WORD_W-1:0] HIGH_MASK = 32'hFF80_0000;
    localparam logic [WORD_W-1:0] LOW_MASK  = 32'h007F_FFFF;

    localparam logic [ADDR_W-1:0] LAST_ADDR     = ADDR_W'(STREAM_LEN - 1);
    localparam logic [ADDR_W-1:0] END_POS       = ADDR_W'(STREAM_LEN);
    localparam logic [ADDR_W-1:0] FIRST_FILL    = ADDR_W'(SEED_WORDS);
    localparam logic [ADDR_W-1:0] LAG_NEAR_A    = ADDR_W'(LAG_NEAR);
    localparam logic [ADDR_W-1:0] LAG_FAR_A     = ADDR_W'(LAG_FAR);
    localparam logic [4:0]        LAST_SEED_W   = 5'(SEED_WORDS - 1);
    localparam logic [4:0]        LAST_ROUND    = 5'd31;
    localparam logic [1:0]        SETUP_PASSES  = 2'(REGEN_PASSES - 1);

    // Control of the shared LCG multiply unit.
    typedef struct packed {
        logic load;
        logic step;
    } t_lcg_ctl;

    // One write request into the key store.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] data;
    } t_mem_wr;

endpackage

FILE: hdl/lxsc_lcg.sv
// ----------------------------------------------------------------------------
// lxsc_lcg: seed register and shared multiply-add unit
// Advances seed = seed * multiplier + 1 by one round per step request.
// ----------------------------------------------------------------------------
module lxsc_lcg (
    input  logic                             i_clk,
    input  lxsc_pkg::t_lcg_ctl               i_ctl,
    input  logic [lxsc_pkg::WORD_W-1:0]      i_seed,
    output logic [lxsc_pkg::WORD_W-1:0]      o_seed_next
);
    import lxsc_pkg::*;

    logic [WORD_W-1:0] r_seed;
    logic [WORD_W-1:0] n_seed;

    // Only the low word of the product is kept.
    assign n_seed      = r_seed * LCG_MUL + WORD_W'(1);
    assign o_seed_next = n_seed;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_seed <= i_seed;
        end else if (i_ctl.step) begin
            r_seed <= n_seed;
        end
    end

endmodule

FILE: hdl/lxsc_ram.sv
// ----------------------------------------------------------------------------
// lxsc_ram: key store memory
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module lxsc_ram (
    input  logic                             i_clk,
    input  lxsc_pkg::t_mem_wr                i_wr,
    input  logic [lxsc_pkg::ADDR_W-1:0]      i_raddr_a,
    input  logic [lxsc_pkg::ADDR_W-1:0]      i_raddr_b,
    output logic [lxsc_pkg::WORD_W-1:0]      o_rdata_a,
    output logic [lxsc_pkg::WORD_W-1:0]      o_rdata_b
);
    import lxsc_pkg::*;

    logic [WORD_W-1:0] r_mem [STREAM_LEN];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

FILE: hdl/lagged_xor_stream_cipher_521_core.sv
// ----------------------------------------------------------------------------
// lagged_xor_stream_cipher_521_core: 32-bit lagged XOR keystream cipher
// Key setup from a seed register into a 521-word store, then data words are
// XORed with the stored keystream word at the current position.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+------------------------------------
//  input    | i_in_valid / o_in_stall    | i_cmd, i_data_in, i_advance
//  output   | o_out_valid / i_out_stall  | o_data_out
//  config   | i_cfg_we (no wait)         | i_cfg_wdata (seed register)
//
// After a data request is accepted, the registered store read lands and then
// the output register is loaded before the next request can be accepted. When
// the position has reached the end of the store, the request first runs one
// regeneration pass over all 521 words (one store word per cycle through the
// two read ports and the write port) plus one read state. A key setup request
// runs 17 seed words of 32 LCG rounds each on the shared multiplier, 504 fill
// words and four regeneration passes; it produces no result.
// Reset clears the position, seed register, state, counters and valid flags; the key
// store itself is not cleared, so key setup must run before any data request.
// A stall on the output only holds the block when a new result is ready while
// the previous one is still waiting in the output register.
// ----------------------------------------------------------------------------
module lagged_xor_stream_cipher_521_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration port
    input  logic                             i_cfg_we,
    input  logic [lxsc_pkg::WORD_W-1:0]      i_cfg_wdata,
    // Request channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_cmd,
    input  logic [lxsc_pkg::WORD_W-1:0]      i_data_in,
    input  logic                             i_advance,
    // Result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [lxsc_pkg::WORD_W-1:0]      o_data_out
);
    import lxsc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GEN,
        ST_FILL,
        ST_REGEN,
        ST_DATA_RD,
        ST_DATA_OUT
    } t_state;

    t_state            r_state;
    logic [WORD_W-1:0] r_seed_cfg;
    logic [ADDR_W-1:0] r_pos;
    logic [ADDR_W-1:0] r_idx;       // fill index, or regeneration read index
    logic [4:0]        r_round;
    logic [4:0]        r_word;
    logic [1:0]        r_pass;      // regeneration passes still to run after this one
    logic [WORD_W-1:0] r_acc;
    logic [WORD_W-1:0] r_sr [SEED_WORDS];  // last 17 store words, entry 0 newest
    logic              r_wr_pend;
    logic [ADDR_W-1:0] r_wr_addr;
    logic              r_cmd;
    logic              r_adv;
    logic [WORD_W-1:0] r_din;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_data;

    t_lcg_ctl          lcg_ctl;
    logic [WORD_W-1:0] seed_next;
    logic [WORD_W-1:0] acc_next;
    logic [WORD_W-1:0] adj_word;
    logic [WORD_W-1:0] gen_word;
    logic [WORD_W-1:0] fill_word;
    logic [WORD_W-1:0] rdata_a;
    logic [WORD_W-1:0] rdata_b;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
    t_mem_wr           mem_wr;
    logic              in_accept;
    logic              out_free;
    logic              word_done;
    logic              push_sr;
    logic [WORD_W-1:0] push_word;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_accept   = i_in_valid && (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_out_data;
    // The output register can take a new result this cycle.
    assign out_free    = !r_out_valid || !i_out_stall;

    // Each round shifts bit 31 of the freshly advanced seed into the top of the
    // accumulator. The accumulator carries over from one word to the next.
    assign acc_next  = {seed_next[WORD_W-1], r_acc[WORD_W-1:1]};
    assign word_done = (r_state == ST_GEN) && (r_round == LAST_ROUND);

    // Word 16 is rebuilt from words 0 and 15, which sit in shift line entries
    // 15 and 0 at that point.
    assign adj_word  = (r_sr[15] >> 9) ^ (acc_next << 23) ^ r_sr[0];
    assign gen_word  = (r_word == LAST_SEED_W) ? adj_word : acc_next;

    // Fill recurrence: entries 0, 16 and 15 hold words i-1, i-17 and i-16.
    assign fill_word = r_sr[0] ^ ((r_sr[16] << 23) & HIGH_MASK)
                     ^ ((r_sr[15] >> 9) & LOW_MASK);

    assign push_sr   = word_done || (r_state == ST_FILL);
    assign push_word = (r_state == ST_FILL) ? fill_word : gen_word;

    always_comb begin
        lcg_ctl.load = in_accept && i_cmd;
        lcg_ctl.step = (r_state == ST_GEN);
    end

    // Regeneration reads the word itself and its partner: the word 489 places
    // ahead for the first 32 words, then the already updated word 32 behind.
    always_comb begin
        raddr_a = (r_state == ST_REGEN) ? r_idx : r_pos;
        raddr_b = (r_idx < LAG_NEAR_A) ? (r_idx + LAG_FAR_A) : (r_idx - LAG_NEAR_A);
    end

    always_comb begin
        mem_wr.en   = 1'b0;
        mem_wr.addr = r_idx;
        mem_wr.data = fill_word;
        if (r_wr_pend) begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = r_wr_addr;
            mem_wr.data = rdata_a ^ rdata_b;
        end else if (word_done) begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = ADDR_W'(r_word);
            mem_wr.data = gen_word;
        end else if (r_state == ST_FILL) begin
            mem_wr.en   = 1'b1;
        end
    end

    lxsc_lcg u_lcg (
        .i_clk       (i_clk),
        .i_ctl       (lcg_ctl),
        .i_seed      (r_seed_cfg),
        .o_seed_next (seed_next)
    );

    lxsc_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    // Shift line of the most recent words written during key setup.
    always_ff @(posedge i_clk) begin
        if (push_sr) begin
            r_sr[0] <= push_word;
            for (int k = 1; k < SEED_WORDS; k++) begin
                r_sr[k] <= r_sr[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_seed_cfg  <= '0;
            r_pos       <= '0;
            r_idx       <= '0;
            r_round     <= '0;
            r_word      <= '0;
            r_pass      <= '0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_seed_cfg <= i_cfg_wdata;
            end

            // A result that was taken leaves the output register empty, unless
            // a new result is loaded in the same cycle.
            if (r_out_valid && !i_out_stall && (r_state != ST_DATA_OUT)) begin
                r_out_valid <= 1'b0;
            end

            // Reads issued during regeneration are written back in the cycle after, once the read data has landed.
            r_wr_pend <= (r_state == ST_REGEN);

            case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_cmd <= i_cmd;
                        r_adv <= i_advance;
                        r_din <= i_data_in;
                        if (i_cmd) begin
                            r_acc   <= '0;
                            r_round <= '0;
                            r_word  <= '0;
                            r_state <= ST_GEN;
                        end else if (r_pos >= END_POS) begin
                            // The store is used up: one regeneration pass first.
                            r_idx   <= '0;
                            r_pass  <= '0;
                            r_state <= ST_REGEN;
                        end else begin
                            // The store read of the position was issued in this
                            // cycle, so the keystream word is ready next cycle.
                            r_state <= ST_DATA_OUT;
                        end
                    end
                end
                ST_GEN: begin
                    r_acc   <= acc_next;
                    r_round <= r_round + 5'd1;
                    if (word_done) begin
                        if (r_word == LAST_SEED_W) begin
                            r_idx   <= FIRST_FILL;
                            r_state <= ST_FILL;
                        end else begin
                            r_word <= r_word + 5'd1;
                        end
                    end
                end
                ST_FILL: begin
                    if (r_idx == LAST_ADDR) begin
                        r_idx   <= '0;
                        r_pass  <= SETUP_PASSES;
                        r_state <= ST_REGEN;
                    end else begin
                        r_idx <= r_idx + ADDR_W'(1);
                    end
                end
                ST_REGEN: begin
                    r_wr_addr <= r_idx;
                    if (r_idx == LAST_ADDR) begin
                        r_idx <= '0;
                        if (r_pass == '0) begin
                            r_pos   <= '0;
                            r_state <= r_cmd ? ST_IDLE : ST_DATA_RD;
                        end else begin
                            r_pass <= r_pass - 2'd1;
                        end
                    end else begin
                        r_idx <= r_idx + ADDR_W'(1);
                    end
                end
                ST_DATA_RD: begin
                    r_state <= ST_DATA_OUT;
                end
                ST_DATA_OUT: begin
                    // The read address still points at the position, so the
                    // read data holds while the output register is full.
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_din ^ rdata_a;
                        if (r_adv) begin
                            r_pos <= r_pos + ADDR_W'(1);
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
